/* rtl/plsa_pkg.sv */
// Shared types and constants for the positional list shift array.
package plsa_pkg;

   // Index width that covers every supported capacity (up to 1024 entries).
   localparam int unsigned IDX_W = 11;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SH_HOLD   = 2'd0,
      SH_INSERT = 2'd1,
      SH_DELETE = 2'd2
   } shift_op_type;

   // Broadcast command that every cell of the row decodes against its index.
   typedef struct packed {
      shift_op_type      op;
      logic [IDX_W-1:0]  lo;     // insert or delete position
      logic [IDX_W-1:0]  hi;     // entry count before the operation
      logic [DATA_W-1:0] value;  // value to place on insert
   } shift_cmd_type;

endpackage

/* rtl/plsa_cell.sv */
// One storage cell of the list row: holds one entry and shifts with its neighbors.
module plsa_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                           clock,
   input  plsa_pkg::shift_cmd_type        cmd,
   input  logic [plsa_pkg::DATA_W-1:0]    below_data,
   input  logic [plsa_pkg::DATA_W-1:0]    above_data,
   output logic [plsa_pkg::DATA_W-1:0]    data
);
   import plsa_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [IDX_W-1:0] MY_IDX_P1 = IDX_W'(INDEX + 1);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         SH_INSERT: begin
            // The cell at the insert point takes the new value, the cells
            // above it up to the old count take the entry below them.
            if (MY_IDX == cmd.lo) begin
               data_in = cmd.value;
            end else if (MY_IDX > cmd.lo && MY_IDX <= cmd.hi) begin
               data_in = below_data;
            end
         end
         SH_DELETE: begin
            if (MY_IDX >= cmd.lo && MY_IDX_P1 < cmd.hi) begin
               data_in = above_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/positional_list_shift_array.sv */
// Top level of the positional list shift array: control, cell row and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries.
// Each request transaction (req_action, req_position, req_value) inserts,
// deletes or reads at a position. An insert at or past the current count
// appends; an insert into a full list is refused with status FULL. A delete
// or read at or past the count is refused with status RANGE. Unused action
// code 3 changes nothing and answers OK with the current count.
// Every request yields exactly one response transaction carrying
// rsp_read_value (zero unless a read succeeds), rsp_count (entries after
// the operation) and rsp_status.
// The entries live in a row of cells; on an insert or delete, the cells
// from the position up to the count move by one place in the same clock.
// The response is registered and shown in the cycle after the request;
// a new request is taken every cycle while the receiver does not stall.
// When the receiver holds rsp_stall with a response waiting, req_stall is
// raised and the pending response holds steady until it is taken.
// Synchronous reset empties the list and drops any pending response; entry
// contents are not cleared, since reads are bounded by the count.
module positional_list_shift_array #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [5:0]          req_position,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_read_value,
   output logic [6:0]          rsp_count,
   output logic [1:0]          rsp_status
);
   import plsa_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   // Only the first 64 cells can be named by a 6-bit position.
   localparam int unsigned RD_N = (CAPACITY < 64) ? CAPACITY : 64;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_value_ff;
   logic [DATA_W-1:0] rsp_read_value_in;
   logic [6:0]        rsp_count_ff;
   logic [6:0]        rsp_count_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;

   logic              accept;
   shift_cmd_type     cmd;
   logic [IDX_W-1:0]  cnt_ext;
   logic [IDX_W-1:0]  pos_ext;
   logic              is_full;
   logic              pos_in_range;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] cell_q [CAPACITY];

   // A response waiting on a stalled receiver blocks the next request.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   assign cnt_ext = IDX_W'(count_ff);
   assign pos_ext = IDX_W'(req_position);
   assign is_full = (cnt_ext == IDX_W'(CAPACITY));
   assign pos_in_range = (pos_ext < cnt_ext);

   // Read port: a select over the cells reachable by a position.
   always_comb begin
      rd_data = '0;
      for (int k = 0; k < RD_N; k++) begin
         if (6'(k) == req_position) begin
            rd_data = cell_q[k];
         end
      end
   end

   // Decode the request into the broadcast shift command and the response.
   always_comb begin
      cmd.op = SH_HOLD;
      cmd.lo = pos_ext;
      cmd.hi = cnt_ext;
      cmd.value = req_value;
      count_in = count_ff;
      rsp_read_value_in = '0;
      rsp_status_in = ST_OK;
      unique case (action_type'(req_action))
         ACT_INSERT: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.op = accept ? SH_INSERT : SH_HOLD;
               // A position past the end appends at the count.
               cmd.lo = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_DELETE: begin
            if (!pos_in_range) begin
               rsp_status_in = ST_RANGE;
            end else begin
               cmd.op = accept ? SH_DELETE : SH_HOLD;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_READ: begin
            if (!pos_in_range) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_read_value_in = rd_data;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
      rsp_count_in = 7'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] below_d;
      logic [DATA_W-1:0] above_d;
      if (g == 0) begin : g_first
         assign below_d = '0;
      end else begin : g_mid_lo
         assign below_d = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign above_d = '0;
      end else begin : g_mid_hi
         assign above_d = cell_q[g+1];
      end
      plsa_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .below_data (below_d),
         .above_data (above_d),
         .data       (cell_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload loads only when a request is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_count_ff <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* verif/positional_list_shift_array_tb.sv */
// Self-checking testbench for the positional list shift array with a predicting scoreboard.
module positional_list_shift_array_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plsa_pkg::*;

   // The list depth that this bench builds the block with and predicts against.
   localparam int unsigned LIST_DEPTH = 64;

   // Action code 3 is not part of the package enum; the block must ignore it.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Random stimulus stops once this many request transactions were accepted.
   localparam int unsigned RANDOM_ITEMS = 750;

   // Watchdog limit. The slowest correct run is roughly 800 transactions, each
   // waiting on idle gaps at the sender, on stalls at the receiver and on the
   // response register, plus a few drain pauses; the limit leaves a wide margin.
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One predicted response transaction.
   typedef struct {
      logic signed [31:0] read_value;
      logic [6:0]         count;
      status_type         status;
   } list_result_type;

   // The scoreboard owns a copy of the list, predicts the response of every
   // accepted request and compares each response with the oldest prediction.
   class list_scoreboard;
      logic signed [31:0] entries [LIST_DEPTH];
      int unsigned        fill;
      list_result_type    expected_q [$];
      int unsigned        errors;

      function new();
         fill = 0;
         errors = 0;
         foreach (entries[i]) entries[i] = '0;
      endfunction

      function int unsigned pending_count();
         return expected_q.size();
      endfunction

      // Apply one accepted request to the shadow list and queue its response.
      function void note_request(logic [1:0] act, logic [5:0] pos, logic signed [31:0] val);
         list_result_type want;
         int unsigned     slot;
         int unsigned     k;
         want.read_value = '0;
         want.status = ST_OK;
         slot = pos;
         case (act)
            ACT_INSERT: begin
               if (fill >= LIST_DEPTH) begin
                  want.status = ST_FULL;
               end else begin
                  if (slot > fill) slot = fill;
                  for (k = fill; k > slot; k--) entries[k] = entries[k - 1];
                  entries[slot] = val;
                  fill++;
               end
            end
            ACT_DELETE: begin
               if (slot >= fill) begin
                  want.status = ST_RANGE;
               end else begin
                  for (k = slot; k + 1 < fill; k++) entries[k] = entries[k + 1];
                  fill--;
               end
            end
            ACT_READ: begin
               if (slot >= fill) want.status = ST_RANGE;
               else want.read_value = entries[slot];
            end
            default: begin
            end
         endcase
         want.count = 7'(fill);
         expected_q.push_back(want);
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(logic signed [31:0] rd, logic [6:0] cnt, logic [1:0] st);
         list_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected response: read_value %0d count %0d status %0d", rd, cnt, st);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (rd !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, rd);
            errors++;
         end
         if (cnt !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, cnt);
            errors++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_READ;
   logic [5:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [6:0]         rsp_count;
   logic [1:0]         rsp_status;

   list_scoreboard sb;
   int unsigned    items_sent = 0;
   int unsigned    cycles = 0;

   // When set, the matching side runs without idle cycles for a while.
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   positional_list_shift_array #(
      .CAPACITY(LIST_DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Values lean on the extremes of the signed range now and then, so that the
   // sign bit and all-ones patterns travel through the shifting cells.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Most positions fall inside the span that the operation accepts, so the
   // list is really edited; one in five is drawn from the whole 6-bit field.
   function automatic logic [5:0] pick_position(int unsigned span);
      if (span == 0 || $urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
      if (span > 64) span = 64;
      return 6'($urandom_range(0, span - 1));
   endfunction

   // Present one request transaction and hold it until the block takes it.
   // Valid stays high after acceptance, so a back-to-back request only swaps
   // the payload; it is lowered only when an idle gap follows or sending stops.
   task automatic send_request(input logic [1:0] act, input logic [5:0] pos,
                               input logic signed [31:0] val);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_position <= pos;
      req_value <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(act, pos, val);
      items_sent++;
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   // One random request whose action mix keeps the list moving both ways.
   task automatic send_mixed();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         send_request(ACT_UNUSED, 6'($urandom_range(0, 63)), pick_value());
      else if (pick <= 8)
         send_request(ACT_INSERT, pick_position(sb.fill + 1), pick_value());
      else if (pick <= 13)
         send_request(ACT_DELETE, pick_position(sb.fill), pick_value());
      else
         send_request(ACT_READ, pick_position(sb.fill), pick_value());
   endtask

   // Receiver: take each response transaction, check it, then hold stall high
   // for a randomly drawn hold, which may be none, before the next one may be taken.
   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            sb.check_response(rsp_read_value, rsp_count, rsp_status);
            hold = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         rsp_stall <= (hold != 0);
         if (hold != 0) hold--;
      end
   end

   // Watchdog: a run that has not finished by the limit has hung.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("positional_list_shift_array_tb NOT OK");
      $finish;
   end

   initial begin
      int unsigned episode;
      int unsigned n;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. An empty list refuses reads and deletes and ignores
      // the unused action code.
      send_request(ACT_READ, 6'd0, 32'sd0);
      send_request(ACT_DELETE, 6'd0, 32'sd0);
      send_request(ACT_READ, 6'd63, 32'sd0);
      send_request(ACT_UNUSED, 6'd63, -32'sd1);
      // Inserts past the count append; others land at the front and middle.
      send_request(ACT_INSERT, 6'd63, 32'sh8000_0000);
      send_request(ACT_INSERT, 6'd0, 32'sh7fff_ffff);
      send_request(ACT_INSERT, 6'd1, 32'sd0);
      send_request(ACT_INSERT, 6'd63, -32'sd1);
      send_request(ACT_INSERT, 6'd2, 32'sh5a5a_a5a5);
      // Reads at the first and last entry, just past the end and far past it.
      send_request(ACT_READ, 6'd0, 32'sd0);
      send_request(ACT_READ, 6'd4, 32'sd0);
      send_request(ACT_READ, 6'd5, 32'sd0);
      send_request(ACT_READ, 6'd63, 32'sd0);
      // Deletes at the last, the first and a middle entry, then out of range.
      send_request(ACT_DELETE, 6'd4, 32'sd0);
      send_request(ACT_DELETE, 6'd0, 32'sd0);
      send_request(ACT_DELETE, 6'd1, 32'sd0);
      send_request(ACT_DELETE, 6'd63, 32'sd0);
      // The unused code on a non-empty list, with a value that must not land.
      send_request(ACT_UNUSED, 6'd0, 32'sh7fff_ffff);
      send_request(ACT_READ, 6'd0, 32'sd0);
      send_request(ACT_READ, 6'd1, 32'sd0);

      // The sender holds off until the block has answered everything.
      wait_for_results();

      // Random part, in episodes. The first fills the list to capacity and
      // then pushes into the full list; the second drains it to empty and
      // keeps deleting. Later episodes pick among filling, draining and a
      // mixed run. Each episode also decides whether either side idles.
      episode = 0;
      while (items_sent < RANDOM_ITEMS) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         n = (episode < 2) ? episode : $urandom_range(0, 9);
         if (n == 0 || n == 3) begin
            while (sb.fill < LIST_DEPTH) begin
               if ($urandom_range(0, 5) == 0)
                  send_request(ACT_READ, pick_position(sb.fill), pick_value());
               else
                  send_request(ACT_INSERT, pick_position(sb.fill + 1), pick_value());
            end
            repeat ($urandom_range(1, 3))
               send_request(ACT_INSERT, 6'($urandom_range(0, 63)), pick_value());
            send_request(ACT_READ, 6'd63, 32'sd0);
         end else if (n == 1 || n == 4) begin
            while (sb.fill > 0) begin
               if ($urandom_range(0, 5) == 0)
                  send_request(ACT_READ, pick_position(sb.fill), pick_value());
               else
                  send_request(ACT_DELETE, pick_position(sb.fill), pick_value());
            end
            repeat ($urandom_range(1, 3))
               send_request(ACT_DELETE, 6'($urandom_range(0, 63)), pick_value());
            send_request(ACT_READ, 6'd0, 32'sd0);
         end else begin
            repeat ($urandom_range(10, 40)) send_mixed();
         end
         if ($urandom_range(0, 7) == 0) wait_for_results();
         episode++;
      end

      // All stimulus is in; drain the responses and let the block settle.
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.pending_count() != 0) begin
         $error("%0d responses still expected at the end", sb.pending_count());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("positional_list_shift_array_tb OK");
      end else begin
         $display("positional_list_shift_array_tb NOT OK");
      end
      $finish;
   end

endmodule
